### hw/rtl/btlv_pkg.sv
// Shared types and constants for the BER tag-length-value deframer.
// No dependencies; imported by ber_tlv_deframer.
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_CNT_W = 7;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [LEN_CNT_W-1:0] len_cnt_t;

endpackage

`default_nettype wire

### hw/rtl/ber_tlv_deframer.sv
// Usage of ber_tlv_deframer:
// - Input channel in_valid/in_ready/in_byte carries one byte of the encoded
//   stream per item. Output channel out_valid/out_ready carries value_byte,
//   record_last and record_empty, one value byte or one empty marker per item.
// - Records are tag, length (short or long big-endian form), value. The tag
//   byte and the length bytes produce no output item. Each value byte is
//   sent; record_last marks the final one. A zero length sends one item with
//   record_empty and record_last set and value_byte zero.
// - Path: an input byte that produces an output item goes through the input
//   register, then the result register, before it shows on out_valid.
// - Throughput: one byte per cycle unless stalled; the phase and length
//   update is a single pass of logic between the input and result registers.
// - Reset (rst_n low) empties both registers and returns the parser to
//   expecting a tag byte.
// - When the receiver stalls, the result register holds its item; the input
//   register holds one more byte, after which in_ready drops until out_ready.
// Depends on btlv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_deframer #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire btlv_pkg::byte_t in_byte,
    output logic                out_valid,
    input  wire                 out_ready,
    output btlv_pkg::byte_t     value_byte,
    output logic                record_last,
    output logic                record_empty
);
    import btlv_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG       = 2'd0,
        PH_LEN_FIRST = 2'd1,
        PH_LEN_MORE  = 2'd2,
        PH_VALUE     = 2'd3
    } phase_t;

    typedef logic [LENGTH_WIDTH-1:0] len_t;

    phase_t   phase_reg, phase_next;
    len_cnt_t len_left_reg, len_left_next;
    len_t     val_left_reg, val_left_next;

    logic  s1_valid_reg;
    byte_t s1_byte_reg;

    logic  out_valid_reg;
    byte_t value_byte_reg;
    logic  record_last_reg;
    logic  record_empty_reg;

    logic     out_free;
    logic     s1_fire;
    logic     emit;
    byte_t    emit_byte;
    logic     emit_last;
    logic     emit_empty;
    len_cnt_t low7;
    len_t     shifted;
    len_t     val_dec;
    len_cnt_t len_dec;
    logic [LENGTH_WIDTH+BYTE_W-1:0] shift_wide;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    assign low7       = s1_byte_reg[LEN_CNT_W-1:0];
    assign shift_wide = {val_left_reg, s1_byte_reg};
    assign shifted    = shift_wide[LENGTH_WIDTH-1:0];
    assign val_dec    = val_left_reg - len_t'(1);
    assign len_dec    = len_left_reg - len_cnt_t'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        len_left_next = len_left_reg;
        val_left_next = val_left_reg;
        emit          = 1'b0;
        emit_byte     = '0;
        emit_last     = 1'b0;
        emit_empty    = 1'b0;
        unique case (phase_reg)
            PH_TAG:
            begin
                phase_next = PH_LEN_FIRST;
            end
            PH_LEN_FIRST:
            begin
                len_left_next = '0;
                if (low7 == '0)
                begin
                    phase_next    = PH_TAG;
                    val_left_next = '0;
                    emit          = 1'b1;
                    emit_last     = 1'b1;
                    emit_empty    = 1'b1;
                end
                else if (!s1_byte_reg[BYTE_W-1])
                begin
                    val_left_next = len_t'(low7);
                    phase_next    = PH_VALUE;
                end
                else
                begin
                    val_left_next = '0;
                    len_left_next = low7;
                    phase_next    = PH_LEN_MORE;
                end
            end
            PH_LEN_MORE:
            begin
                val_left_next = shifted;
                len_left_next = len_dec;
                if (len_dec == '0)
                begin
                    if (shifted == '0)
                    begin
                        phase_next = PH_TAG;
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_empty = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                if (val_left_reg == '0)
                begin
                    phase_next = PH_LEN_FIRST;
                end
                else
                begin
                    val_left_next = val_dec;
                    emit          = 1'b1;
                    emit_byte     = s1_byte_reg;
                    emit_last     = (val_dec == '0);
                    if (val_dec == '0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TAG;
            len_left_reg     <= '0;
            val_left_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s1_byte_reg      <= '0;
            out_valid_reg    <= 1'b0;
            value_byte_reg   <= '0;
            record_last_reg  <= 1'b0;
            record_empty_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
                s1_byte_reg  <= in_byte;
            end
            if (s1_fire)
            begin
                phase_reg    <= phase_next;
                len_left_reg <= len_left_next;
                val_left_reg <= val_left_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_fire && emit;
            end
            if (s1_fire && emit)
            begin
                value_byte_reg   <= emit_byte;
                record_last_reg  <= emit_last;
                record_empty_reg <= emit_empty;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign value_byte   = value_byte_reg;
    assign record_last  = record_last_reg;
    assign record_empty = record_empty_reg;

`ifndef SYNTHESIS
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_empty |-> record_last && value_byte == '0)
        else $error("empty marker without last flag or with nonzero byte");

    a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> val_left_reg != '0)
        else $error("value phase with no bytes left");

    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEN_MORE |-> len_left_reg != '0)
        else $error("length phase with no length bytes left");

    a_no_advance_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(phase_reg) && $stable(val_left_reg))
        else $error("parser advanced while result register was stalled");
`endif

endmodule

`default_nettype wire
